/* design/min_separation_point_inserter_macros.svh */
// Assertion macros shared by the point inserter RTL.
`ifndef MIN_SEPARATION_POINT_INSERTER_MACROS_SVH
`define MIN_SEPARATION_POINT_INSERTER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define MSP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

/* design/msp_pkg.sv */
// Types and constants shared by the point inserter modules.
package msp_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY   = 4096;
    localparam int DEF_COORD_BITS = 16;

    // Configuration register widths and port format
    localparam int SEP_W     = 12;
    localparam int TGT_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int LIM_W     = 2 * SEP_W;

    localparam logic [SEP_W-1:0] SEP_RESET = 12'd358;
    localparam logic [TGT_W-1:0] TGT_RESET = 13'd4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_CLOSE  = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_FIRST,
        S_LAST,
        S_BIS_RD,
        S_BIS_CHK,
        S_PRB_RD,
        S_PRB_DIF,
        S_PRB_MUL,
        S_PRB_EVAL,
        S_SH_START,
        S_SH,
        S_SH_DRAIN,
        S_WRITE,
        S_RESULT
    } t_state;

    // Neighbor probe verdict
    typedef struct packed {
        logic close;
        logic stop;
    } t_probe_res;

endpackage

/* design/msp_probe.sv */
// Neighbor distance probe: abs differences, squares, then limit compares.
module msp_probe #(
    parameter int COORD_BITS = msp_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic [3*COORD_BITS-1:0]       i_cand,
    input  logic [3*COORD_BITS-1:0]       i_entry,
    input  logic [msp_pkg::LIM_W-1:0]     i_lim,
    output msp_pkg::t_probe_res           o_res
);
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > msp_pkg::LIM_W + 1) ? SUM_W : msp_pkg::LIM_W + 1;

    logic [COORD_BITS-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]       r_sqx, r_sqy, r_sqz;
    logic [SUM_W-1:0]      w_sum;

    // Absolute difference of one coordinate field
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Stage 1: per-axis absolute differences
    always_ff @(posedge i_clk) begin
        r_dx <= abs_diff(i_cand[COORD_BITS-1:0], i_entry[COORD_BITS-1:0]);
        r_dy <= abs_diff(i_cand[2*COORD_BITS-1:COORD_BITS],
                         i_entry[2*COORD_BITS-1:COORD_BITS]);
        r_dz <= abs_diff(i_cand[3*COORD_BITS-1:2*COORD_BITS],
                         i_entry[3*COORD_BITS-1:2*COORD_BITS]);
    end

    // Stage 2: squares
    always_ff @(posedge i_clk) begin
        r_sqx <= {{COORD_BITS{1'b0}}, r_dx} * {{COORD_BITS{1'b0}}, r_dx};
        r_sqy <= {{COORD_BITS{1'b0}}, r_dy} * {{COORD_BITS{1'b0}}, r_dy};
        r_sqz <= {{COORD_BITS{1'b0}}, r_dz} * {{COORD_BITS{1'b0}}, r_dz};
    end

    // Full-width sum never wraps, so no saturation is needed for the compare
    assign w_sum = {2'b00, r_sqx} + {2'b00, r_sqy} + {2'b00, r_sqz};

    assign o_res.close = CMP_W'(w_sum) <= CMP_W'(i_lim);
    assign o_res.stop  = CMP_W'(r_sqz) > CMP_W'({i_lim, 1'b0});

endmodule

/* design/min_separation_point_inserter.sv */
// An item runs a bisection search, a neighbor probe (read, diff, square, evaluate) per
//   probed neighbor, a shift of the entries above the position, then the write and result.
// One item at a time: a new candidate is taken only once the result is loaded; the
//   sorted-insert shift through the single store read port dominates for uniform z.
// Reset (synchronous, active low): count cleared, min_separation 358, target_count 4096;
//   the point store is not cleared, reads are gated by the count.
`include "min_separation_point_inserter_macros.svh"

module min_separation_point_inserter #(
    parameter int CAPACITY   = msp_pkg::DEF_CAPACITY,
    parameter int COORD_BITS = msp_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // candidate channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [COORD_BITS-1:0]             i_point_x,
    input  logic [COORD_BITS-1:0]             i_point_y,
    input  logic [COORD_BITS-1:0]             i_point_z,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_status,
    output logic [$clog2(CAPACITY+1)-1:0]     o_insert_position,
    output logic [$clog2(CAPACITY+1)-1:0]     o_stored_count,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msp_pkg::CFG_W-1:0]         i_cfg_data
);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int ENT_W  = 3 * COORD_BITS;
    localparam int FULL_W = (CNT_W > msp_pkg::TGT_W) ? CNT_W : msp_pkg::TGT_W;

    // Point store: {z, y, x}, one write and one registered read per cycle
    logic [ENT_W-1:0] mem [CAPACITY];
    logic [ENT_W-1:0] r_rdata;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ENT_W-1:0]  w_wdata;

    msp_pkg::t_state  r_state, n_state;
    msp_pkg::t_status r_status, n_status;

    logic [COORD_BITS-1:0]     r_px, r_py, r_pz;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_lo, n_lo, r_hi, n_hi;
    logic [CNT_W-1:0]          r_pos, n_pos;
    logic [CNT_W-1:0]          r_k, n_k;
    logic                      r_dir_up, n_dir_up;
    logic                      r_wpend, n_wpend;
    logic [CNT_W-1:0]          r_waddr, n_waddr;
    logic [msp_pkg::SEP_W-1:0] r_min_sep;
    logic [msp_pkg::TGT_W-1:0] r_target;
    logic [msp_pkg::LIM_W-1:0] r_lim;

    logic                      r_out_valid;
    msp_pkg::t_status          r_out_status;
    logic [CNT_W-1:0]          r_out_pos, r_out_count;

    logic [COORD_BITS-1:0]     w_rd_z;
    logic [CNT_W-1:0]          w_last, w_mid, w_k_inc, w_k_dec;
    logic [CNT_W:0]            w_mid_sum;
    logic                      w_full;
    logic                      w_in_acc;
    logic                      w_out_load;
    msp_pkg::t_probe_res       w_probe;

    // Handshake
    assign o_stall    = (r_state != msp_pkg::S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_load = (r_state == msp_pkg::S_RESULT) && (!r_out_valid || !i_stall);

    // Helpers
    assign w_rd_z    = r_rdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_last    = r_count - CNT_W'(1);
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[CNT_W:1];
    assign w_k_inc   = r_k + CNT_W'(1);
    assign w_k_dec   = r_k - CNT_W'(1);
    assign w_full    = (FULL_W'(r_count) >= FULL_W'(r_target))
                    || (r_count >= CNT_W'(CAPACITY));

    // Squared limit, recomputed from the register
    always_ff @(posedge i_clk) begin
        r_lim <= {{msp_pkg::SEP_W{1'b0}}, r_min_sep} * {{msp_pkg::SEP_W{1'b0}}, r_min_sep};
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sep <= msp_pkg::SEP_RESET;
            r_target  <= msp_pkg::TGT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msp_pkg::REG_MIN_SEP: r_min_sep <= i_cfg_data[msp_pkg::SEP_W-1:0];
                msp_pkg::REG_TARGET:  r_target  <= i_cfg_data[msp_pkg::TGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Candidate capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
        end
    end

    // Store access
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_rd_addr];
    end

    // Distance probe
    msp_probe #(
        .COORD_BITS (COORD_BITS)
    ) u_probe (
        .i_clk   (i_clk),
        .i_cand  ({r_pz, r_py, r_px}),
        .i_entry (r_rdata),
        .i_lim   (r_lim),
        .o_res   (w_probe)
    );

    // Controller state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msp_pkg::S_IDLE;
            r_count <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wpend <= n_wpend;
        end
    end

    // Working registers of the current item
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_dir_up <= n_dir_up;
        r_waddr  <= n_waddr;
    end

    // Next state, store addressing
    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_pos     = r_pos;
        n_k       = r_k;
        n_dir_up  = r_dir_up;
        n_wpend   = 1'b0;
        n_waddr   = r_waddr;
        w_rd_addr = r_k[ADDR_W-1:0];
        // a pending shift write lands in the cycle after its read
        w_we      = r_wpend;
        w_waddr   = r_waddr[ADDR_W-1:0];
        w_wdata   = r_rdata;

        case (r_state)
            msp_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = msp_pkg::S_START;
                end
            end

            msp_pkg::S_START: begin
                if (w_full) begin
                    n_status = msp_pkg::ST_FULL;
                    n_pos    = '0;
                    n_state  = msp_pkg::S_RESULT;
                end else if (r_count == '0) begin
                    n_pos   = '0;
                    n_state = msp_pkg::S_WRITE;
                end else begin
                    w_rd_addr = '0;
                    n_state   = msp_pkg::S_FIRST;
                end
            end

            // candidate at or below the first z goes to the front
            msp_pkg::S_FIRST: begin
                if (r_pz <= w_rd_z) begin
                    n_pos    = '0;
                    n_k      = '0;
                    n_dir_up = 1'b0;
                    n_state  = msp_pkg::S_PRB_RD;
                end else begin
                    w_rd_addr = w_last[ADDR_W-1:0];
                    n_state   = msp_pkg::S_LAST;
                end
            end

            // at or above the last z: append, downward scan from the last entry
            msp_pkg::S_LAST: begin
                if (r_pz >= w_rd_z) begin
                    n_pos    = r_count;
                    n_k      = w_last;
                    n_dir_up = 1'b0;
                    n_state  = msp_pkg::S_PRB_RD;
                end else begin
                    n_lo    = '0;
                    n_hi    = w_last;
                    n_state = msp_pkg::S_BIS_RD;
                end
            end

            // bisection: hi is the first probe above the candidate
            msp_pkg::S_BIS_RD: begin
                if ((r_hi - r_lo) > CNT_W'(1)) begin
                    w_rd_addr = w_mid[ADDR_W-1:0];
                    n_state   = msp_pkg::S_BIS_CHK;
                end else begin
                    n_pos    = r_hi;
                    n_k      = r_hi;
                    n_dir_up = 1'b0;
                    n_state  = msp_pkg::S_PRB_RD;
                end
            end

            msp_pkg::S_BIS_CHK: begin
                if (r_pz < w_rd_z) begin
                    n_hi = w_mid;
                end else begin
                    n_lo = w_mid;
                end
                n_state = msp_pkg::S_BIS_RD;
            end

            // neighbor probe: read, diff, square, evaluate
            msp_pkg::S_PRB_RD: begin
                w_rd_addr = r_k[ADDR_W-1:0];
                n_state   = msp_pkg::S_PRB_DIF;
            end

            msp_pkg::S_PRB_DIF: begin
                n_state = msp_pkg::S_PRB_MUL;
            end

            msp_pkg::S_PRB_MUL: begin
                n_state = msp_pkg::S_PRB_EVAL;
            end

            msp_pkg::S_PRB_EVAL: begin
                if (w_probe.close) begin
                    n_status = msp_pkg::ST_CLOSE;
                    n_pos    = '0;
                    n_state  = msp_pkg::S_RESULT;
                end else if (!r_dir_up) begin
                    if (w_probe.stop || (r_k == '0)) begin
                        // downward done; upward scan only if entries lie above pos
                        if (r_pos < r_count) begin
                            n_k      = r_pos;
                            n_dir_up = 1'b1;
                            n_state  = msp_pkg::S_PRB_RD;
                        end else begin
                            n_state = msp_pkg::S_SH_START;
                        end
                    end else begin
                        n_k     = w_k_dec;
                        n_state = msp_pkg::S_PRB_RD;
                    end
                end else begin
                    if (w_probe.stop || (w_k_inc == r_count)) begin
                        n_state = msp_pkg::S_SH_START;
                    end else begin
                        n_k     = w_k_inc;
                        n_state = msp_pkg::S_PRB_RD;
                    end
                end
            end

            // shift entries pos..count-1 up by one, top first
            msp_pkg::S_SH_START: begin
                if (r_pos == r_count) begin
                    n_state = msp_pkg::S_WRITE;
                end else begin
                    n_k     = w_last;
                    n_state = msp_pkg::S_SH;
                end
            end

            msp_pkg::S_SH: begin
                w_rd_addr = r_k[ADDR_W-1:0];
                n_wpend   = 1'b1;
                n_waddr   = w_k_inc;
                if (r_k == r_pos) begin
                    n_state = msp_pkg::S_SH_DRAIN;
                end else begin
                    n_k = w_k_dec;
                end
            end

            msp_pkg::S_SH_DRAIN: begin
                n_state = msp_pkg::S_WRITE;
            end

            msp_pkg::S_WRITE: begin
                w_we     = 1'b1;
                w_waddr  = r_pos[ADDR_W-1:0];
                w_wdata  = {r_pz, r_py, r_px};
                n_count  = r_count + CNT_W'(1);
                n_status = msp_pkg::ST_ACCEPT;
                n_state  = msp_pkg::S_RESULT;
            end

            msp_pkg::S_RESULT: begin
                if (w_out_load) begin
                    n_state = msp_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = msp_pkg::S_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_pos    <= r_pos;
            r_out_count  <= r_count;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_insert_position = r_out_pos;
    assign o_stored_count    = r_out_count;

    // Checks
    `MSP_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "point count above capacity")
    `MSP_ASSERT(a_count_step, ($past(i_rst_n) && (r_count != $past(r_count))) |-> (r_count == $past(r_count) + CNT_W'(1)), "point count moved by more than one")
    `MSP_ASSERT(a_shift_addr, r_wpend |-> (r_waddr <= r_count), "shift write beyond the filled store")
    `MSP_ASSERT_NEVER(a_reject_pos, o_valid && (o_status != msp_pkg::ST_ACCEPT) && (o_insert_position != '0), "refused point reports a position")

endmodule

/* tb/sv/point_store_checker.sv */
// Checker for the point inserter: keeps its own z-sorted point store and compares results.
`timescale 1ns / 1ps

module point_store_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // candidate channel
    input  logic                              i_cand_valid,
    input  logic                              i_cand_stall,
    input  logic [msp_pkg::DEF_COORD_BITS-1:0] i_point_x,
    input  logic [msp_pkg::DEF_COORD_BITS-1:0] i_point_y,
    input  logic [msp_pkg::DEF_COORD_BITS-1:0] i_point_z,
    // result channel
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic [1:0]                        i_status,
    input  logic [$clog2(msp_pkg::DEF_CAPACITY+1)-1:0] i_insert_position,
    input  logic [$clog2(msp_pkg::DEF_CAPACITY+1)-1:0] i_stored_count,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msp_pkg::CFG_W-1:0]         i_cfg_data,
    // to the testbench top
    output int unsigned                       o_pending,
    output int unsigned                       o_mismatches
);
    import msp_pkg::*;

    localparam int CAP   = DEF_CAPACITY;
    localparam int COORD = DEF_COORD_BITS;
    localparam int CW    = $clog2(CAP + 1);

    typedef struct packed {
        t_status       status;
        logic [CW-1:0] position;
        logic [CW-1:0] count;
    } t_outcome;

    // Shadow copy of the store, sorted by z
    logic [COORD-1:0] xs [CAP];
    logic [COORD-1:0] ys [CAP];
    logic [COORD-1:0] zs [CAP];
    int unsigned      point_count;
    logic [SEP_W-1:0] sep_reg;
    logic [TGT_W-1:0] tgt_reg;

    t_outcome    outcome_queue[$];
    int unsigned n_bad = 0;

    function automatic longint unsigned sq_gap(input logic [COORD-1:0] a, input logic [COORD-1:0] b);
        longint unsigned d;
        d = (a >= b) ? a - b : b - a;
        return d * d;
    endfunction

    // Sums stay far below 2^64 at 16-bit coordinates, so no saturation is needed
    function automatic bit entry_too_near(input int unsigned idx,
                                          input logic [COORD-1:0] px, py, pz,
                                          input longint unsigned lim, margin,
                                          output bit halt);
        longint unsigned dz2;
        dz2  = sq_gap(pz, zs[idx]);
        halt = dz2 > margin;
        return (sq_gap(px, xs[idx]) + sq_gap(py, ys[idx]) + dz2) <= lim;
    endfunction

    // Search, neighbor scan and sorted insert for one candidate
    function automatic t_outcome predict_insertion(input logic [COORD-1:0] px, py, pz);
        t_outcome        res;
        int unsigned     n, pos, lo, hi, mid, i;
        int              k;
        longint unsigned s, lim, margin;
        bit              too_near, halt;
        n        = point_count;
        pos      = 0;
        too_near = 1'b0;
        res.status = ST_ACCEPT;
        if (n >= tgt_reg || n >= CAP) begin
            res.status = ST_FULL;
        end else if (n > 0) begin
            s      = sep_reg;
            lim    = s * s;
            margin = 2 * lim;
            if (pz <= zs[0]) begin
                pos = 0;
            end else if (pz >= zs[n-1]) begin
                pos = n;
            end else begin
                lo = 0;
                hi = n - 1;
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    if (pz < zs[mid]) hi = mid;
                    else lo = mid;
                end
                pos = hi;
            end
            // downward scan; past the top it starts at the last valid entry
            for (k = int'((pos == n) ? n - 1 : pos); k >= 0; k--) begin
                if (entry_too_near(unsigned'(k), px, py, pz, lim, margin, halt)) begin
                    too_near = 1'b1;
                    break;
                end
                if (halt) break;
            end
            // upward scan
            if (!too_near) begin
                for (i = pos; i < n; i++) begin
                    if (entry_too_near(i, px, py, pz, lim, margin, halt)) begin
                        too_near = 1'b1;
                        break;
                    end
                    if (halt) break;
                end
            end
            if (too_near) res.status = ST_CLOSE;
        end
        if (res.status == ST_ACCEPT) begin
            for (i = n; i > pos; i--) begin
                xs[i] = xs[i-1];
                ys[i] = ys[i-1];
                zs[i] = zs[i-1];
            end
            xs[pos] = px;
            ys[pos] = py;
            zs[pos] = pz;
            point_count = n + 1;
        end else begin
            pos = 0;
        end
        res.position = pos[CW-1:0];
        res.count    = point_count[CW-1:0];
        return res;
    endfunction

    // Watch all three ports at each edge
    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome fresh;
        if (!i_rst_n) begin
            point_count = 0;
            sep_reg     = SEP_RESET;
            tgt_reg     = TGT_RESET;
            outcome_queue.delete();
        end else begin
            // result beat
            if (i_res_valid && !i_res_stall) begin
                if (outcome_queue.size() == 0) begin
                    $display("%0t: result beat with no outcome expected (status %0d)",
                             $time, i_status);
                    n_bad++;
                end else begin
                    want = outcome_queue.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_status);
                        n_bad++;
                    end
                    if (i_insert_position !== want.position) begin
                        $display("%0t: insert_position expected %0d, got %0d",
                                 $time, want.position, i_insert_position);
                        n_bad++;
                    end
                    if (i_stored_count !== want.count) begin
                        $display("%0t: stored_count expected %0d, got %0d",
                                 $time, want.count, i_stored_count);
                        n_bad++;
                    end
                end
            end
            // register write
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MIN_SEP: sep_reg = i_cfg_data[SEP_W-1:0];
                    REG_TARGET:  tgt_reg = i_cfg_data[TGT_W-1:0];
                    default: ;
                endcase
            end
            // candidate beat
            if (i_cand_valid && !i_cand_stall) begin
                fresh         = predict_insertion(i_point_x, i_point_y, i_point_z);
                outcome_queue = {outcome_queue, fresh};
            end
        end
        o_pending    <= outcome_queue.size();
        o_mismatches <= n_bad;
    end

endmodule

/* tb/sv/testbench.sv */
// Testbench top for the point inserter: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import msp_pkg::*;

    localparam int COORD      = DEF_COORD_BITS;
    localparam int CW         = $clog2(DEF_CAPACITY + 1);
    localparam int IDLE_LIMIT = 50000;
    localparam int RAND_ITEMS = 90;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cand_valid = 1'b0;
    logic             cand_stall;
    logic [COORD-1:0] pt_x = '0;
    logic [COORD-1:0] pt_y = '0;
    logic [COORD-1:0] pt_z = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    logic [1:0]       res_status;
    logic [CW-1:0]    res_pos;
    logic [CW-1:0]    res_count;
    logic             cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_SEP;
    logic [CFG_W-1:0] cfg_data = '0;

    int unsigned pending;
    int unsigned mismatches;
    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 50;
    int unsigned idle_cycles = 0;
    int unsigned cur_sep = 358;
    logic [3*COORD-1:0] sent_points[$];

    always #5 clk = ~clk;

    min_separation_point_inserter DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (cand_valid),
        .o_stall           (cand_stall),
        .i_point_x         (pt_x),
        .i_point_y         (pt_y),
        .i_point_z         (pt_z),
        .o_valid           (res_valid),
        .i_stall           (res_stall),
        .o_status          (res_status),
        .o_insert_position (res_pos),
        .o_stored_count    (res_count),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    point_store_checker checker_inst (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cand_valid      (cand_valid),
        .i_cand_stall      (cand_stall),
        .i_point_x         (pt_x),
        .i_point_y         (pt_y),
        .i_point_z         (pt_z),
        .i_res_valid       (res_valid),
        .i_res_stall       (res_stall),
        .i_status          (res_status),
        .i_insert_position (res_pos),
        .i_stored_count    (res_count),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_pending         (pending),
        .o_mismatches      (mismatches)
    );

    // Result-side backpressure
    always @(posedge clk) begin
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: cycles without any beat or register write
    always @(posedge clk) begin
        if (!rst_n || (cand_valid && !cand_stall) || (res_valid && !res_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Both registers in back-to-back cycles; only called while the block is idle
    task automatic write_regs(input logic [CFG_W-1:0] sep_data, input logic [CFG_W-1:0] tgt_data);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_SEP;
        cfg_data  <= sep_data;
        @(posedge clk);
        cfg_index <= REG_TARGET;
        cfg_data  <= tgt_data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_sep = sep_data[SEP_W-1:0];
    endtask

    // One candidate beat, with an optional random gap ahead of it
    task automatic send_point(input logic [COORD-1:0] x, y, z);
        logic [3*COORD-1:0] pt;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            cand_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        cand_valid <= 1'b1;
        pt_x <= x;
        pt_y <= y;
        pt_z <= z;
        pt = {x, y, z};
        sent_points = {sent_points, pt};
        @(posedge clk);
        while (cand_stall) @(posedge clk);
    endtask

    // Hold off the sender until every outcome has come back
    task automatic wait_drained();
        cand_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [COORD-1:0] jitter(input logic [COORD-1:0] base, input int span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[COORD-1:0];
    endfunction

    // Mostly near-misses around earlier points and a dense cluster, some uniform noise
    function automatic void next_candidate(output logic [COORD-1:0] x, y, z);
        logic [3*COORD-1:0] base;
        int unsigned        r;
        int                 span;
        r    = $urandom_range(0, 99);
        base = sent_points[$urandom_range(0, sent_points.size() - 1)];
        span = 2 * cur_sep + 8;
        if (r < 12) begin
            {x, y, z} = base;
        end else if (r < 52) begin
            x = jitter(base[3*COORD-1:2*COORD], span);
            y = jitter(base[2*COORD-1:COORD], span);
            z = jitter(base[COORD-1:0], span);
        end else if (r < 75) begin
            x = COORD'(16'h4000 + $urandom_range(0, 6 * cur_sep + 64));
            y = COORD'(16'h4000 + $urandom_range(0, 6 * cur_sep + 64));
            z = COORD'(16'd30000 + $urandom_range(0, 4 * cur_sep + 16));
        end else begin
            x = COORD'($urandom_range(0, 65535));
            y = COORD'($urandom_range(0, 65535));
            z = COORD'($urandom_range(0, 65535));
        end
    endfunction

    task automatic run_random(input int n_items);
        logic [COORD-1:0] x, y, z;
        for (int i = 0; i < n_items; i++) begin
            next_candidate(x, y, z);
            send_point(x, y, z);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_regs(13'd358, 13'd4096);

        // Directed: empty store, search edges, bisection, distance boundary
        send_point(16'd0, 16'd0, 16'd0);
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_point(16'd32768, 16'd32768, 16'd32768);
        send_point(16'd32968, 16'd32768, 16'd32768);
        send_point(16'd32768, 16'd33168, 16'd32868);
        send_point(16'd0, 16'hFFFF, 16'd0);
        send_point(16'd100, 16'd65435, 16'd50);
        send_point(16'hFFFF, 16'd0, 16'hFFFF);
        send_point(16'hFFFF, 16'd200, 16'd65435);
        send_point(16'd16384, 16'd16384, 16'd16384);
        send_point(16'd16742, 16'd16384, 16'd16384);
        send_point(16'd16743, 16'd16384, 16'd16384);
        send_point(16'd49152, 16'd0, 16'd16384);
        send_point(16'hAAAA, 16'h5555, 16'hAAAA);
        send_point(16'h5555, 16'hAAAA, 16'h5555);

        // Zero separation: only an exact duplicate is refused
        wait_drained();
        write_regs(13'd0, 13'd4096);
        send_point(16'd0, 16'd0, 16'd0);
        send_point(16'd1, 16'd0, 16'd0);

        // Largest separation
        wait_drained();
        write_regs(13'd4095, 13'd4096);
        send_point(16'd20000, 16'd20000, 16'd20000);
        send_point(16'd21000, 16'd21000, 16'd21000);

        // Store full: target below the count, then zero
        wait_drained();
        write_regs(13'd358, 13'd1);
        send_point(16'd1000, 16'd1000, 16'd1000);
        wait_drained();
        write_regs(13'd358, 13'd0);
        send_point(16'd2000, 16'd2000, 16'd2000);

        // Random, sender idles little and receiver often
        wait_drained();
        write_regs(13'd358, 13'd4096);
        run_random(RAND_ITEMS);

        // Random, roles swapped; top data bit set on the separation write
        wait_drained();
        send_idle_pct = 50;
        recv_idle_pct = 16;
        write_regs({1'b1, 12'($urandom_range(100, 1500))}, 13'd4096);
        run_random(RAND_ITEMS);

        // Random, no idling, target low enough to fill up
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_regs(13'($urandom_range(0, 4095)), 13'($urandom_range(100, 250)));
        run_random(RAND_ITEMS);

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
